// File: rtl/pwl_pkg.sv
package pwl_pkg;

  // width of every temperature code and limit
  localparam int unsigned DataW = 16;

  // kind codes of an input word
  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_WRITE  = 1'b1;

  // one table point as stored in the ram
  typedef struct packed {
    logic [DataW-1:0] temp_ref;
    logic [DataW-1:0] low;
    logic [DataW-1:0] high;
  } point_t;

  // lookup sequencer
  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_SCAN,
    S_MUL,
    S_DIV,
    S_APPLY,
    S_OUT
  } state_e;

endpackage

// File: rtl/pwl_ram.sv
module pwl_ram #(
  parameter int Width = 48,
  parameter int Depth = 20
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/piecewise_linear_limit_lookup_core.sv
// Write word: taken while idle, no result; ready stays high.
// Lookup word: the point scan reads one table point per cycle from the ram; interpolation
// then runs one multiply, 16 divide steps and one apply per limit on the shared unit.
// One lookup at a time: ready is low from acceptance of a lookup until the result word is taken.
// Reset (rst_ni low, asynchronous) clears the point valid bits and the held limits to zero.
module piecewise_linear_limit_lookup_core #(
  parameter int TABLE_POINTS = 20
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      kind_i,
  input  logic [4:0]                entry_index_i,
  input  logic [pwl_pkg::DataW-1:0] point_temperature_i,
  input  logic [pwl_pkg::DataW-1:0] point_low_i,
  input  logic [pwl_pkg::DataW-1:0] point_high_i,
  input  logic [pwl_pkg::DataW-1:0] temperature_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      found_o,
  output logic [pwl_pkg::DataW-1:0] low_limit_o,
  output logic [pwl_pkg::DataW-1:0] high_limit_o
);

  localparam int AW = $clog2(TABLE_POINTS);
  localparam int XW = (AW > 5) ? AW : 5;
  localparam int DW = pwl_pkg::DataW;
  localparam int PW = $bits(pwl_pkg::point_t);
  localparam logic [AW-1:0] LastIdx = AW'(TABLE_POINTS - 1);

  pwl_pkg::state_e state_q, state_d;

  logic                   in_acc, out_acc;
  logic                   wr_en;
  logic [XW-1:0]          idx_wide;
  logic [AW-1:0]          rd_addr;
  logic [PW-1:0]          rd_data;
  pwl_pkg::point_t        cur_pt;
  logic [TABLE_POINTS-1:0] valid_q;
  logic                   vld_rd_q;

  logic [DW-1:0]          t_q;
  pwl_pkg::point_t        prev_q, next_q;
  logic [AW-1:0]          nxt_q;
  logic                   found_q;
  logic [DW-1:0]          held_low_q, held_high_q;
  logic                   sel_q;
  logic                   neg_q;
  logic [DW-1:0]          num_q, den_q;
  logic [2*DW-1:0]        sh_q;
  logic [DW:0]            rem_q;
  logic [3:0]             cnt_q;

  logic                   first_bad;
  logic [DW-1:0]          op_a, op_b;
  logic [DW:0]            diff;
  logic [DW-1:0]          diff_mag;
  logic [DW-1:0]          rem_src;
  logic [DW:0]            trial;
  logic                   qbit;
  logic [DW-1:0]          quo_adj, blend_res;

  assign in_ready_o  = (state_q == pwl_pkg::S_IDLE);
  assign out_valid_o = (state_q == pwl_pkg::S_OUT);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_o && out_ready_i;
  assign found_o     = found_q;
  assign low_limit_o = held_low_q;
  assign high_limit_o = held_high_q;

  // table write port
  assign idx_wide = XW'(entry_index_i);
  assign wr_en    = in_acc && (kind_i == pwl_pkg::KIND_WRITE) &&
                    (int'(entry_index_i) < TABLE_POINTS);

  // read address: point 0 while idle, then walk forward one point a cycle
  always_comb begin
    case (state_q)
      pwl_pkg::S_IDLE:  rd_addr = '0;
      pwl_pkg::S_FIRST: rd_addr = AW'(1);
      pwl_pkg::S_SCAN:  rd_addr = (nxt_q == LastIdx) ? '0 : nxt_q + AW'(1);
      default:          rd_addr = '0;
    endcase
  end

  pwl_ram #(
    .Width(PW),
    .Depth(TABLE_POINTS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(idx_wide[AW-1:0]),
    .wdata_i({point_temperature_i, point_low_i, point_high_i}),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  // a point never written reads as zero
  assign cur_pt = vld_rd_q ? pwl_pkg::point_t'(rd_data) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_q[idx_wide[AW-1:0]] <= 1'b1;
      end
      vld_rd_q <= valid_q[rd_addr];
    end
  end

  assign first_bad = (cur_pt.temp_ref == '0) || (cur_pt.low == '0) ||
                     (cur_pt.high == '0) || (cur_pt.high < cur_pt.low);

  // shared blend unit operands: low limits first, then high limits
  assign op_a     = sel_q ? prev_q.high : prev_q.low;
  assign op_b     = sel_q ? next_q.high : next_q.low;
  assign diff     = {1'b0, op_b} - {1'b0, op_a};
  assign diff_mag = diff[DW] ? DW'(-diff) : diff[DW-1:0];

  // one restoring divide step per cycle
  assign rem_src = (cnt_q == '0) ? sh_q[2*DW-1:DW] : rem_q[DW-1:0];
  assign trial   = {rem_src, sh_q[DW-1]};
  assign qbit    = (trial >= {1'b0, den_q});

  // floor of a negative quotient rounds away from zero
  assign quo_adj   = sh_q[DW-1:0] + DW'(neg_q && (rem_q != '0));
  assign blend_res = neg_q ? op_a - quo_adj : op_a + quo_adj;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pwl_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pwl_pkg::S_IDLE: begin
        if (in_acc && (kind_i == pwl_pkg::KIND_LOOKUP)) begin
          state_d = pwl_pkg::S_FIRST;
        end
      end
      pwl_pkg::S_FIRST: begin
        if (first_bad || (t_q <= cur_pt.temp_ref)) begin
          state_d = pwl_pkg::S_OUT;
        end else begin
          state_d = pwl_pkg::S_SCAN;
        end
      end
      pwl_pkg::S_SCAN: begin
        if (cur_pt.temp_ref == '0) begin
          state_d = pwl_pkg::S_OUT;
        end else if (t_q <= cur_pt.temp_ref) begin
          state_d = pwl_pkg::S_MUL;
        end else if (nxt_q == LastIdx) begin
          state_d = pwl_pkg::S_OUT;
        end
      end
      pwl_pkg::S_MUL:   state_d = pwl_pkg::S_DIV;
      pwl_pkg::S_DIV: begin
        if (cnt_q == 4'hF) begin
          state_d = pwl_pkg::S_APPLY;
        end
      end
      pwl_pkg::S_APPLY: state_d = sel_q ? pwl_pkg::S_OUT : pwl_pkg::S_MUL;
      pwl_pkg::S_OUT: begin
        if (out_acc) begin
          state_d = pwl_pkg::S_IDLE;
        end
      end
      default: state_d = pwl_pkg::S_IDLE;
    endcase
  end

  // held limits and result flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_low_q  <= '0;
      held_high_q <= '0;
      found_q     <= 1'b0;
    end else begin
      case (state_q)
        pwl_pkg::S_FIRST: begin
          if (first_bad) begin
            found_q <= 1'b0;
          end else if (t_q <= cur_pt.temp_ref) begin
            found_q     <= 1'b1;
            held_low_q  <= cur_pt.low;
            held_high_q <= cur_pt.high;
          end
        end
        pwl_pkg::S_SCAN: begin
          if (cur_pt.temp_ref == '0) begin
            found_q     <= 1'b1;
            held_low_q  <= prev_q.low;
            held_high_q <= prev_q.high;
          end else if (t_q <= cur_pt.temp_ref) begin
            found_q <= 1'b1;
          end else if (nxt_q == LastIdx) begin
            found_q <= 1'b0;
          end
        end
        pwl_pkg::S_APPLY: begin
          if (sel_q) begin
            held_high_q <= blend_res;
          end else begin
            held_low_q <= blend_res;
          end
        end
        default: ;
      endcase
    end
  end

  // scan and blend datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      pwl_pkg::S_IDLE: begin
        t_q <= temperature_i;
      end
      pwl_pkg::S_FIRST: begin
        prev_q <= cur_pt;
        nxt_q  <= AW'(1);
      end
      pwl_pkg::S_SCAN: begin
        if (t_q <= cur_pt.temp_ref) begin
          next_q <= cur_pt;
          num_q  <= t_q - prev_q.temp_ref;
          den_q  <= cur_pt.temp_ref - prev_q.temp_ref;
          sel_q  <= 1'b0;
        end else begin
          prev_q <= cur_pt;
          nxt_q  <= nxt_q + AW'(1);
        end
      end
      pwl_pkg::S_MUL: begin
        sh_q  <= (2*DW)'(diff_mag) * (2*DW)'(num_q);
        neg_q <= diff[DW];
        cnt_q <= '0;
      end
      pwl_pkg::S_DIV: begin
        rem_q <= qbit ? trial - {1'b0, den_q} : trial;
        sh_q  <= {sh_q[2*DW-2:0], qbit};
        cnt_q <= cnt_q + 4'd1;
      end
      pwl_pkg::S_APPLY: begin
        sel_q <= 1'b1;
      end
      default: ;
    endcase
  end

  // a result is never shown while a new word could be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> !in_ready_o)
    else $error("result shown while ready");

  // taking the result frees the block in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_acc |=> in_ready_o)
    else $error("block not idle after result taken");

  // the divisor of an interpolation is never zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pwl_pkg::S_DIV) |-> (den_q != '0))
    else $error("zero divisor in blend");

  // partial remainder stays below the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == pwl_pkg::S_DIV) && (cnt_q != '0)) |-> (rem_q < {1'b0, den_q}))
    else $error("divide remainder out of range");

  // the interpolated temperature lies inside its segment
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pwl_pkg::S_MUL) |-> ((num_q != '0) && (num_q <= den_q)))
    else $error("temperature outside segment");

endmodule
